>>> rtl/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_STEPS          = 24;

    localparam int ANGLE_W = 18;
    localparam int HW      = 20;
    localparam int ZW      = 25;
    localparam int XW      = 33;
    localparam int CW      = 22;
    localparam int PW      = 2 * CW;
    localparam int QW      = PW + CW;
    localparam int SW      = QW + 1;
    localparam int OUT_W   = 16;

    localparam int HALF_TURN_Q9    = 92160;
    localparam int FULL_TURN_Q9    = 184320;
    localparam int QUARTER_TURN_Q9 = 46080;

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032875;

    localparam logic [22:0] ATAN_TBL [ATAN_STEPS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
    };

endpackage
`default_nettype wire

>>> rtl/euler_to_quaternion_unit.sv
// Data pass through the input register, the CORDIC steps, the cos/sin register, the product registers and the output.
// Throughput: one item per cycle while the output is not stalled; the CORDIC has one register stage per step.
// A stall on the output holds the whole pipeline, so no item is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`default_nettype none
module euler_to_quaternion_unit
    import e2q_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic signed [ANGLE_W-1:0]   i_roll_deg,
    input  wire logic signed [ANGLE_W-1:0]   i_pitch_deg,
    input  wire logic signed [ANGLE_W-1:0]   i_yaw_deg,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [OUT_W-1:0]          o_quat_w,
    output logic signed [OUT_W-1:0]          o_quat_x,
    output logic signed [OUT_W-1:0]          o_quat_y,
    output logic signed [OUT_W-1:0]          o_quat_z
);

    localparam int ITERS = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
    localparam int NST   = ITERS + 5;

    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) <<< 44)) >>> 45;
        if (r > SW'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -SW'(32768)) begin
            return 16'sh8000;
        end
        return r[OUT_W-1:0];
    endfunction

    logic adv;
    logic r_v [NST];

    logic signed [XW-1:0] r_x [ITERS+1][3];
    logic signed [XW-1:0] r_y [ITERS+1][3];
    logic signed [ZW-1:0] r_z [ITERS+1][3];
    logic                 r_f [ITERS+1][3];

    logic signed [CW-1:0] r_c [3];
    logic signed [CW-1:0] r_s [3];

    logic signed [PW-1:0] r_ccr, r_ssr, r_csr, r_scr;
    logic signed [CW-1:0] r_cp, r_sp;
    logic signed [QW-1:0] r_w1, r_w2, r_x1, r_x2, r_y1, r_y2, r_z1, r_z2;

    logic signed [ANGLE_W-1:0] ang [3];

    assign adv     = !r_v[NST-1] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_v[NST-1];
    assign ang[0]  = i_roll_deg;
    assign ang[1]  = i_pitch_deg;
    assign ang[2]  = i_yaw_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < NST; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    genvar l, k;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            logic signed [HW-1:0] h0, h1, h2;
            logic                 fl;
            logic signed [XW-1:0] xr, yr;

            always_comb begin
                h0 = HW'(ang[l]);
                if (h0 >= HW'(HALF_TURN_Q9)) begin
                    h1 = h0 - HW'(FULL_TURN_Q9);
                end else if (h0 < -HW'(HALF_TURN_Q9)) begin
                    h1 = h0 + HW'(FULL_TURN_Q9);
                end else begin
                    h1 = h0;
                end
                if (h1 > HW'(QUARTER_TURN_Q9)) begin
                    h2 = h1 - HW'(HALF_TURN_Q9);
                    fl = 1'b1;
                end else if (h1 < -HW'(QUARTER_TURN_Q9)) begin
                    h2 = h1 + HW'(HALF_TURN_Q9);
                    fl = 1'b1;
                end else begin
                    h2 = h1;
                    fl = 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_x[0][l] <= CORDIC_GAIN_Q30;
                    r_y[0][l] <= '0;
                    r_z[0][l] <= ZW'(h2) <<< 7;
                    r_f[0][l] <= fl;
                end
            end

            for (k = 0; k < ITERS; k++) begin : g_step
                logic signed [XW-1:0] dx, dy;
                logic signed [ZW-1:0] at;
                assign dx = r_y[k][l] >>> k;
                assign dy = r_x[k][l] >>> k;
                assign at = ZW'(ATAN_TBL[k]);

                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        if (r_z[k][l] >= 0) begin
                            r_x[k+1][l] <= r_x[k][l] - dx;
                            r_y[k+1][l] <= r_y[k][l] + dy;
                            r_z[k+1][l] <= r_z[k][l] - at;
                        end else begin
                            r_x[k+1][l] <= r_x[k][l] + dx;
                            r_y[k+1][l] <= r_y[k][l] - dy;
                            r_z[k+1][l] <= r_z[k][l] + at;
                        end
                        r_f[k+1][l] <= r_f[k][l];
                    end
                end
            end

            assign xr = (r_x[ITERS][l] + XW'(512)) >>> 10;
            assign yr = (r_y[ITERS][l] + XW'(512)) >>> 10;

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_c[l] <= r_f[ITERS][l] ? -xr[CW-1:0] : xr[CW-1:0];
                    r_s[l] <= r_f[ITERS][l] ? -yr[CW-1:0] : yr[CW-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ccr <= r_c[2] * r_c[0];
            r_ssr <= r_s[2] * r_s[0];
            r_csr <= r_c[2] * r_s[0];
            r_scr <= r_s[2] * r_c[0];
            r_cp  <= r_c[1];
            r_sp  <= r_s[1];

            r_w1 <= r_ccr * r_cp;
            r_w2 <= r_ssr * r_sp;
            r_x1 <= r_csr * r_cp;
            r_x2 <= r_scr * r_sp;
            r_y1 <= r_ccr * r_sp;
            r_y2 <= r_ssr * r_cp;
            r_z1 <= r_scr * r_cp;
            r_z2 <= r_csr * r_sp;

            o_quat_w <= f_sat(SW'(r_w1) + SW'(r_w2));
            o_quat_x <= f_sat(SW'(r_x1) - SW'(r_x2));
            o_quat_y <= f_sat(SW'(r_y1) + SW'(r_y2));
            o_quat_z <= f_sat(SW'(r_z1) - SW'(r_z2));
        end
    end

endmodule
`default_nettype wire

>>> rtl/e2q_checker.sv
`default_nettype none
module e2q_checker
    import e2q_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_stall,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic signed [OUT_W-1:0]   o_quat_w,
    input wire logic signed [OUT_W-1:0]   o_quat_x
);

    a_stall_only_when_blocked: assert property (@(posedge i_clk)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match a blocked output item");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output item valid right after reset");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quat_w) && $stable(o_quat_x))
        else $error("stalled output item changed");

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_quat_w (o_quat_w),
    .o_quat_x (o_quat_x)
);
`default_nettype wire

>>> tb/euler_to_quaternion_unit_test.sv
`timescale 1ns / 1ps
module euler_to_quaternion_unit_test;
    import e2q_pkg::*;

    localparam int ITERS = TRIG_ITERATIONS_DEF;
    localparam int LATENCY = ((ITERS < ATAN_STEPS) ? ITERS : ATAN_STEPS) + 5;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } t_angles;

    typedef struct packed {
        logic signed [OUT_W-1:0] w;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_quat;

    logic i_clk;
    logic i_rst_n;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [ANGLE_W-1:0] i_roll_deg = '0, i_pitch_deg = '0, i_yaw_deg = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    euler_to_quaternion_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_roll_deg(i_roll_deg), .i_pitch_deg(i_pitch_deg), .i_yaw_deg(i_yaw_deg),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y), .o_quat_z(o_quat_z)
    );

    t_angles pending_angles[$];
    t_quat expected_quats[$];
    int error_count = 0;
    bit calm = 0;
    bit hold_sender = 0;
    int send_gap = 0;
    int recv_gap = 0;

    localparam longint ATAN_Q16 [ATAN_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void half_trig(input logic signed [ANGLE_W-1:0] raw,
                                      output longint c, output longint s);
        longint h, x, y, z, dx, dy;
        bit flip;
        h = raw;
        x = 652032875;
        y = 0;
        flip = 0;
        if (h >= HALF_TURN_Q9) h -= FULL_TURN_Q9;
        if (h < -HALF_TURN_Q9) h += FULL_TURN_Q9;
        if (h > QUARTER_TURN_Q9) begin
            h -= HALF_TURN_Q9;
            flip = 1;
        end else if (h < -QUARTER_TURN_Q9) begin
            h += HALF_TURN_Q9;
            flip = 1;
        end
        z = h * 128;
        for (int i = 0; i < ITERS && i < ATAN_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_Q16[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_Q16[i];
            end
        end
        x = floor_shift(x + 512, 10);
        y = floor_shift(y + 512, 10);
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [OUT_W-1:0] round_q15(logic signed [127:0] v);
        logic signed [127:0] r;
        r = (v + (128'sd1 <<< 44)) >>> 45;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_quat angles_to_quat(t_angles a);
        longint cr, sr, cp, sp, cy, sy;
        t_quat q;
        half_trig(a.roll, cr, sr);
        half_trig(a.pitch, cp, sp);
        half_trig(a.yaw, cy, sy);
        q.w = round_q15(128'(cy) * cr * cp + 128'(sy) * sr * sp);
        q.x = round_q15(128'(cy) * sr * cp - 128'(sy) * cr * sp);
        q.y = round_q15(128'(cy) * cr * sp + 128'(sy) * sr * cp);
        q.z = round_q15(128'(sy) * cr * cp - 128'(cy) * sr * sp);
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        case ($urandom_range(0, 5))
            0: return ANGLE_W'($urandom());
            1: return ANGLE_W'($signed($urandom_range(0, 184320)) - 92160);
            2: return ANGLE_W'($signed($urandom_range(0, 4000)) - 2000);
            default: return ANGLE_W'($signed($urandom_range(0, 368640)) - 184320);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_quats.push_back(angles_to_quat(
                    {i_roll_deg, i_pitch_deg, i_yaw_deg}));
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 0;
                end else if (hold_sender || pending_angles.size() == 0) begin
                    i_valid <= 0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    i_valid <= 0;
                end else begin
                    t_angles a;
                    a = pending_angles.pop_front();
                    i_valid <= 1;
                    i_roll_deg <= a.roll;
                    i_pitch_deg <= a.pitch;
                    i_yaw_deg <= a.yaw;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_quats.size() == 0) begin
                    report_mismatch("unexpected item", int'(o_quat_w), 0);
                end else begin
                    t_quat q;
                    q = expected_quats.pop_front();
                    if (o_quat_w !== q.w) report_mismatch("w", int'(o_quat_w), int'(q.w));
                    if (o_quat_x !== q.x) report_mismatch("x", int'(o_quat_x), int'(q.x));
                    if (o_quat_y !== q.y) report_mismatch("y", int'(o_quat_y), int'(q.y));
                    if (o_quat_z !== q.z) report_mismatch("z", int'(o_quat_z), int'(q.z));
                end
            end
        end
        if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 3);
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    initial begin
        int extremes [6];
        int waited;
        extremes = '{-131072, 131071, -92160, 92160, 46080, 0};
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        for (int k = 0; k < 6; k++)
            pending_angles.push_back({ANGLE_W'(extremes[k]), ANGLE_W'(extremes[(k + 1) % 6]),
                                      ANGLE_W'(extremes[(k + 3) % 6])});
        pending_angles.push_back({18'sd0, 18'sd0, 18'sd0});
        pending_angles.push_back({-18'sd46081, 18'sd46081, -18'sd46080});
        pending_angles.push_back({18'sd92159, -18'sd92161, ANGLE_W'(184320)});
        pending_angles.push_back({18'sd23040, 18'sd23040, 18'sd23040});
        pending_angles.push_back({18'sd131071, 18'sd131071, 18'sd131071});
        pending_angles.push_back({ANGLE_W'(-131072), ANGLE_W'(-131072), ANGLE_W'(-131072)});

        for (int k = 0; k < 300; k++)
            pending_angles.push_back({random_angle(), random_angle(), random_angle()});
        wait (pending_angles.size() == 0);

        hold_sender = 1;
        wait (expected_quats.size() == 0 && !i_valid);
        @(posedge i_clk);
        hold_sender = 0;

        for (int k = 0; k < 350; k++)
            pending_angles.push_back({random_angle(), random_angle(), random_angle()});
        wait (pending_angles.size() < 100);
        calm = 1;
        wait (pending_angles.size() == 0);
        waited = 0;
        while ((expected_quats.size() != 0 || i_valid) && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_quats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/e2q_pkg.sv
rtl/euler_to_quaternion_unit.sv
rtl/e2q_checker.sv
tb/euler_to_quaternion_unit_test.sv
